/* sv/sfld_pkg.sv */
`default_nettype none
package sfld_pkg;

	// Field widths
	localparam int STATUS_W = 8;
	localparam int TIME_W   = 32;
	localparam int WIN_W    = 16;
	localparam int THR_W    = 8;
	localparam int LOCK_W   = 16;
	localparam int CNT_W    = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW    = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_LOCKOUT   = 2'd2
	} cfg_reg_t;

	// Reset values of the registers
	localparam logic [WIN_W-1:0]  WINDOW_RST    = 16'd120;
	localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd6;
	localparam logic [LOCK_W-1:0] LOCKOUT_RST   = 16'd1800;

	// Stream widths
	localparam int S_DATA_W = STATUS_W + TIME_W;
	localparam int M_DATA_W = 8;

	typedef struct packed {
		logic [WIN_W-1:0]  window_seconds;
		logic [THR_W-1:0]  change_threshold;
		logic [LOCK_W-1:0] lockout_seconds;
	} cfg_t;

endpackage
`default_nettype wire

/* sv/switch_flap_lockout_detector.sv */
// Switch flap lockout detector.
// Slave stream carries one status sample per transfer: s_tdata holds status
// in bits 7:0 and now_seconds in bits 39:8. Master stream returns one result
// per sample: m_tdata bit 0 is switching_frequently, bits 7:1 are zero.
// Configuration writes go through cfg_valid/cfg_index/cfg_data (cfg_ready is
// always high): index 0 window_seconds, 1 change_threshold, 2 lockout_seconds;
// other indexes are ignored. Write configuration only while the block is idle.
// Path: a sample accepted on the slave side passes through the input
// register, then the result register, before it is offered on the master
// side. Throughput: one sample per cycle while results are taken; the whole
// state update is one pass between those two registers.
// Reset: config and detector state return to defaults, both streams empty.
// When the receiver stalls, the result holds in its register and one more
// sample is taken into the input register; s_tready then drops until the
// result is taken.
`default_nettype none
module switch_flap_lockout_detector import sfld_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,   // status[7:0], now_seconds[39:8]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_DATA_W-1:0]        m_tdata,   // switching_frequently[0], zero[7:1]
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                cfg;
	logic                valid_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [TIME_W-1:0]   now_s1;
	logic                advance;
	logic                flag_next;
	logic                valid_s2;
	logic                flag_s2;

	assign cfg_ready = 1'b1;

	sfld_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Stage handshake
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			status_s1 <= s_tdata[STATUS_W-1:0];
			now_s1    <= s_tdata[S_DATA_W-1:STATUS_W];
		end
	end

	sfld_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.status      (status_s1),
		.now_seconds (now_s1),
		.cfg         (cfg),
		.flag_next   (flag_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flag_s2 <= flag_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(M_DATA_W-1){1'b0}}, flag_s2};

endmodule
`default_nettype wire

/* sv/sfld_cfg_regs.sv */
`default_nettype none
module sfld_cfg_regs import sfld_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// Register file, writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_seconds   <= WINDOW_RST;
			cfg_q.change_threshold <= THRESHOLD_RST;
			cfg_q.lockout_seconds  <= LOCKOUT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WINDOW:    cfg_q.window_seconds   <= wr_data[WIN_W-1:0];
				REG_THRESHOLD: cfg_q.change_threshold <= wr_data[THR_W-1:0];
				REG_LOCKOUT:   cfg_q.lockout_seconds  <= wr_data[LOCK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* sv/sfld_core.sv */
`default_nettype none
module sfld_core import sfld_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [STATUS_W-1:0] status,
	input  wire logic [TIME_W-1:0]   now_seconds,
	input  wire cfg_t                cfg,
	output logic                     flag_next
);

	logic                monitoring_q;
	logic                have_last_q;
	logic [STATUS_W-1:0] last_status_q;
	logic [TIME_W-1:0]   window_start_q;
	logic [CNT_W-1:0]    change_count_q;
	logic [TIME_W-1:0]   lockout_end_q;
	logic                flag_q;

	logic                monitoring_d;
	logic                have_last_d;
	logic [STATUS_W-1:0] last_status_d;
	logic [TIME_W-1:0]   window_start_d;
	logic [CNT_W-1:0]    change_count_d;
	logic [TIME_W-1:0]   lockout_end_d;
	logic                flag_d;

	logic [TIME_W-1:0]   ws_eff;
	logic                changed;
	logic [CNT_W-1:0]    cnt_inc;
	logic [TIME_W:0]     win_limit;
	logic                win_expired;
	logic [CNT_W-1:0]    cnt_win;
	logic                trip;
	logic [TIME_W:0]     lock_sum;
	logic [TIME_W-1:0]   lock_end_sat;

	// Monitoring datapath: change count, window restart, trip test
	always_comb begin
		ws_eff    = have_last_q ? window_start_q : now_seconds;
		changed   = have_last_q && (last_status_q != status);
		cnt_inc   = (changed && (change_count_q != '1)) ? change_count_q + 1'b1
		                                                 : change_count_q;
		win_limit = {1'b0, ws_eff} + {{(TIME_W+1-WIN_W){1'b0}}, cfg.window_seconds};
		win_expired = {1'b0, now_seconds} > win_limit;
		cnt_win   = win_expired ? '0 : cnt_inc;
		trip      = cnt_win > cfg.change_threshold;
		lock_sum  = {1'b0, now_seconds} + {{(TIME_W+1-LOCK_W){1'b0}}, cfg.lockout_seconds};
		lock_end_sat = lock_sum[TIME_W] ? '1 : lock_sum[TIME_W-1:0];
	end

	// Next state
	always_comb begin
		monitoring_d   = monitoring_q;
		have_last_d    = have_last_q;
		last_status_d  = last_status_q;
		window_start_d = window_start_q;
		change_count_d = change_count_q;
		lockout_end_d  = lockout_end_q;
		flag_d         = flag_q;
		if (monitoring_q) begin
			have_last_d    = 1'b1;
			last_status_d  = status;
			window_start_d = win_expired ? now_seconds : ws_eff;
			change_count_d = cnt_win;
			if (trip) begin
				lockout_end_d  = lock_end_sat;
				monitoring_d   = 1'b0;
				change_count_d = '0;
				have_last_d    = 1'b0;
				flag_d         = 1'b1;
			end
		end else if (now_seconds > lockout_end_q) begin
			lockout_end_d = '0;
			monitoring_d  = 1'b1;
			flag_d        = 1'b0;
		end
	end

	assign flag_next = flag_d;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			monitoring_q   <= 1'b1;
			have_last_q    <= 1'b0;
			last_status_q  <= '0;
			window_start_q <= '0;
			change_count_q <= '0;
			lockout_end_q  <= '0;
			flag_q         <= 1'b0;
		end else if (step) begin
			monitoring_q   <= monitoring_d;
			have_last_q    <= have_last_d;
			last_status_q  <= last_status_d;
			window_start_q <= window_start_d;
			change_count_q <= change_count_d;
			lockout_end_q  <= lockout_end_d;
			flag_q         <= flag_d;
		end
	end

endmodule
`default_nettype wire

/* sv/sfld_checker.sv */
`default_nettype none
module sfld_checker import sfld_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [M_DATA_W-1:0]   m_tdata
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Result valid drops only after a transfer
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result dropped without transfer");

	// With the result register empty the input side cannot be blocked
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// Pad bits of the result stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_DATA_W-1:1] == '0))
		else $error("nonzero pad bits in result");

endmodule

bind switch_flap_lockout_detector sfld_checker u_sfld_checker (.*);
`default_nettype wire
